/* hdl/psb_pkg.sv */
// Shared types and constants of the palette scaler blitter.
package psb_pkg;

  localparam int DEF_SRC_W = 320;
  localparam int DEF_SRC_H = 200;

  localparam int DIM_W    = 13;
  localparam int PITCH_W  = 15;
  localparam int CNT_W    = 12;
  localparam int SCALE_W  = 5;
  localparam int MARGIN_W = 12;
  localparam int ADDR_W   = 26;
  localparam int COLOR_W  = 32;
  localparam int BYTES_W  = 3;
  localparam int PIX_W    = 8;
  localparam int INDEX_W  = 16;
  localparam int CFG_W    = 15;

  localparam int SCREEN_CAP = 4096;
  localparam int SCALE_CAP  = 31;
  localparam int PAL_DEPTH  = 256;
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_PALETTE = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_DRAW    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_ROW_PITCH     = 2'd2,
    CFG_DEPTH_MODE    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DEPTH_32 = 2'd0,
    DEPTH_24 = 2'd1,
    DEPTH_16 = 2'd2
  } depth_mode_t;

  localparam logic [BYTES_W-1:0] BYTES_32 = 3'd4;
  localparam logic [BYTES_W-1:0] BYTES_24 = 3'd3;
  localparam logic [BYTES_W-1:0] BYTES_16 = 3'd2;
  localparam logic [COLOR_W-1:0] MASK_24  = 32'h00ff_ffff;
  localparam logic [COLOR_W-1:0] MASK_16  = 32'h0000_ffff;

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_DRAW    = 2'd2
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0]   screen_width;
    logic [DIM_W-1:0]   screen_height;
    logic [PITCH_W-1:0] row_pitch;
    logic [1:0]         depth_mode;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
    logic [BYTES_W-1:0] bytes;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT,
    ST_RD,
    ST_PAL,
    ST_OUT
  } back_state_t;

endpackage

/* hdl/psb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module psb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/psb_front.sv */
// Front end: accepts input words, sorts them into commands and queues them.
module psb_front #(
  parameter int SRC_W = psb_pkg::DEF_SRC_W,
  parameter int SRC_H = psb_pkg::DEF_SRC_H
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    palette_index,
  input  logic [psb_pkg::COLOR_W-1:0]   palette_color,
  input  logic [psb_pkg::INDEX_W-1:0]   pixel_address,
  input  logic [psb_pkg::PIX_W-1:0]     pixel_value,
  output logic                          cmd_valid,
  output psb_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  localparam int FRAME_SIZE = SRC_W * SRC_H;
  localparam int PTR_W      = $clog2(psb_pkg::CMDQ_DEPTH);

  psb_pkg::cmd_t    q [psb_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  psb_pkg::cmd_t cmd_in;
  logic          keep;
  logic          accept;
  logic          wr_en;
  logic          pix_in_range;

  assign accept       = push && !full;
  assign pix_in_range = 32'(pixel_address) < 32'(FRAME_SIZE);

  // kind 3 and out-of-frame pixel writes are taken and dropped here
  always_comb begin
    cmd_in = '0;
    keep   = 1'b0;
    case (kind)
      psb_pkg::KIND_PALETTE: begin
        cmd_in.op    = psb_pkg::OP_PALETTE;
        cmd_in.index = psb_pkg::INDEX_W'(palette_index);
        cmd_in.data  = palette_color;
        keep         = 1'b1;
      end
      psb_pkg::KIND_PIXEL: begin
        cmd_in.op    = psb_pkg::OP_PIXEL;
        cmd_in.index = pixel_address;
        cmd_in.data  = psb_pkg::COLOR_W'(pixel_value);
        keep         = pix_in_range;
      end
      psb_pkg::KIND_DRAW: begin
        cmd_in.op = psb_pkg::OP_DRAW;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign wr_en     = accept && keep;
  assign full      = count == (PTR_W+1)'(psb_pkg::CMDQ_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !cmd_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (!wr_en && cmd_pop) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

/* hdl/psb_outq.sv */
// Result queue between the back end and the output side.
module psb_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_push,
  input  psb_pkg::result_t            res,
  output logic                        res_full,
  output logic                        empty,
  input  logic                        pop,
  output logic [psb_pkg::ADDR_W-1:0]  fb_address,
  output logic [psb_pkg::COLOR_W-1:0] fb_data,
  output logic [psb_pkg::BYTES_W-1:0] byte_count,
  output logic                        frame_last
);

  localparam int PTR_W = $clog2(psb_pkg::OUTQ_DEPTH);

  psb_pkg::result_t q [psb_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             rd_en;
  psb_pkg::result_t head;

  assign res_full = count == (PTR_W+1)'(psb_pkg::OUTQ_DEPTH);
  assign empty    = count == '0;
  assign rd_en    = pop && !empty;
  assign head     = q[rd_ptr];

  assign fb_address = head.addr;
  assign fb_data    = head.data;
  assign byte_count = head.bytes;
  assign frame_last = head.last;

  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (res_push && !rd_en) begin
        count <= count + (PTR_W+1)'(1);
      end else if (!res_push && rd_en) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

/* hdl/psb_back.sv */
// Back end: store writes, per-frame scale fit, raster walk and pixel output.
module psb_back #(
  parameter int SRC_W = psb_pkg::DEF_SRC_W,
  parameter int SRC_H = psb_pkg::DEF_SRC_H
) (
  input  logic             clk,
  input  logic             rst,
  input  psb_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  input  psb_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_push,
  output psb_pkg::result_t res,
  input  logic             res_full
);

  localparam int FRAME_SIZE = SRC_W * SRC_H;
  localparam int FA_W       = $clog2(FRAME_SIZE);
  localparam int SX_W       = $clog2(SRC_W);
  localparam int SPW        = $clog2((psb_pkg::SCALE_CAP + 1) * SRC_W + 1);
  localparam int SPH        = $clog2((psb_pkg::SCALE_CAP + 1) * SRC_H + 1);
  localparam int CWW        = (SPW > psb_pkg::DIM_W) ? SPW : psb_pkg::DIM_W;
  localparam int CWH        = (SPH > psb_pkg::DIM_W) ? SPH : psb_pkg::DIM_W;
  localparam int PROD_W     = psb_pkg::DIM_W + psb_pkg::PITCH_W;
  localparam int XOFF_W     = psb_pkg::DIM_W + 2;
  localparam int DW         = psb_pkg::DIM_W;

  psb_pkg::back_state_t state;
  psb_pkg::back_state_t state_next;

  // frame geometry latched at the first draw of a frame
  logic [psb_pkg::SCALE_W-1:0]  scale;
  logic [psb_pkg::MARGIN_W-1:0] left_margin;
  logic [psb_pkg::MARGIN_W-1:0] top_margin;
  logic [DW-1:0]                draw_width;
  logic [DW-1:0]                draw_height;

  // raster walk
  logic [psb_pkg::CNT_W-1:0]   col;
  logic [psb_pkg::CNT_W-1:0]   row;
  logic [psb_pkg::SCALE_W-1:0] col_sub;
  logic [psb_pkg::SCALE_W-1:0] row_sub;
  logic [SX_W-1:0]             src_x;
  logic [FA_W-1:0]             row_base;
  logic [FA_W-1:0]             src_idx;

  // scale search
  logic [psb_pkg::SCALE_W-1:0] fit_s;
  logic [SPW-1:0]              span_w;
  logic [SPH-1:0]              span_h;
  logic [CWW-1:0]              span_w_up;
  logic [CWH-1:0]              span_h_up;
  logic [CWW-1:0]              diff_w;
  logic [CWH-1:0]              diff_h;
  logic                        w_gt;
  logic                        h_gt;
  logic                        fit_more;
  logic                        fit_ok;
  logic [DW-1:0]               w_sat;
  logic [DW-1:0]               h_sat;

  logic                        at_origin;
  logic                        is_draw;
  logic                        pal_we;
  logic                        frame_we;
  logic                        pal_re;
  logic                        frame_re;
  logic [psb_pkg::PIX_W-1:0]   frame_rdata;
  logic [psb_pkg::COLOR_W-1:0] pal_rdata;

  logic [PROD_W-1:0]           prod;
  logic [DW-1:0]               ypos;
  logic [DW-1:0]               xpos;
  logic [XOFF_W-1:0]           xoff;
  logic [PROD_W-1:0]           addr_sum;
  logic                        last_col;
  logic                        last_row;
  logic                        col_wrap;
  logic                        row_wrap;

  psb_ram #(
    .WIDTH (psb_pkg::COLOR_W),
    .DEPTH (psb_pkg::PAL_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (cmd.index[7:0]),
    .wdata (cmd.data),
    .re    (pal_re),
    .raddr (frame_rdata),
    .rdata (pal_rdata)
  );

  psb_ram #(
    .WIDTH (psb_pkg::PIX_W),
    .DEPTH (FRAME_SIZE)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (FA_W'(cmd.index)),
    .wdata (cmd.data[psb_pkg::PIX_W-1:0]),
    .re    (frame_re),
    .raddr (src_idx),
    .rdata (frame_rdata)
  );

  assign w_sat = (cfg.screen_width > DW'(psb_pkg::SCREEN_CAP)) ?
                 DW'(psb_pkg::SCREEN_CAP) : cfg.screen_width;
  assign h_sat = (cfg.screen_height > DW'(psb_pkg::SCREEN_CAP)) ?
                 DW'(psb_pkg::SCREEN_CAP) : cfg.screen_height;

  assign span_w_up = CWW'(span_w) + CWW'(SRC_W);
  assign span_h_up = CWH'(span_h) + CWH'(SRC_H);
  assign fit_more  = (fit_s != psb_pkg::SCALE_W'(psb_pkg::SCALE_CAP)) &&
                     (span_w_up <= CWW'(w_sat)) && (span_h_up <= CWH'(h_sat));
  assign fit_ok    = (w_sat != '0) && (h_sat != '0);
  assign w_gt      = CWW'(w_sat) > CWW'(span_w);
  assign h_gt      = CWH'(h_sat) > CWH'(span_h);
  assign diff_w    = CWW'(w_sat) - CWW'(span_w);
  assign diff_h    = CWH'(h_sat) - CWH'(span_h);

  assign at_origin = (col == '0) && (row == '0);
  assign is_draw   = cmd.op == psb_pkg::OP_DRAW;
  assign src_idx   = row_base + FA_W'(src_x);

  assign last_col = ({1'b0, col} + DW'(1)) >= draw_width;
  assign last_row = ({1'b0, row} + DW'(1)) >= draw_height;
  assign col_wrap = col_sub == (scale - psb_pkg::SCALE_W'(1));
  assign row_wrap = row_sub == (scale - psb_pkg::SCALE_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psb_pkg::ST_IDLE: begin
        if (cmd_valid && is_draw) begin
          state_next = at_origin ? psb_pkg::ST_FIT : psb_pkg::ST_RD;
        end
      end
      psb_pkg::ST_FIT: begin
        if (!fit_more) begin
          state_next = fit_ok ? psb_pkg::ST_RD : psb_pkg::ST_IDLE;
        end
      end
      psb_pkg::ST_RD: begin
        state_next = psb_pkg::ST_PAL;
      end
      psb_pkg::ST_PAL: begin
        state_next = psb_pkg::ST_OUT;
      end
      psb_pkg::ST_OUT: begin
        if (!res_full) begin
          state_next = psb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psb_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop  = 1'b0;
    pal_we   = 1'b0;
    frame_we = 1'b0;
    frame_re = 1'b0;
    pal_re   = 1'b0;
    res_push = 1'b0;
    case (state)
      psb_pkg::ST_IDLE: begin
        cmd_pop  = cmd_valid;
        pal_we   = cmd_valid && (cmd.op == psb_pkg::OP_PALETTE);
        frame_we = cmd_valid && (cmd.op == psb_pkg::OP_PIXEL);
      end
      psb_pkg::ST_RD: begin
        frame_re = 1'b1;
      end
      psb_pkg::ST_PAL: begin
        pal_re = 1'b1;
      end
      psb_pkg::ST_OUT: begin
        res_push = !res_full;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row term of the byte address, registered ahead of the final add
  assign ypos = DW'(top_margin) + DW'(row);

  always_ff @(posedge clk) begin
    if (state == psb_pkg::ST_PAL) begin
      prod <= PROD_W'(ypos) * PROD_W'(cfg.row_pitch);
    end
  end

  // result word
  assign xpos = DW'(left_margin) + DW'(col);

  always_comb begin
    res.last = last_col && last_row;
    case (cfg.depth_mode)
      psb_pkg::DEPTH_24: begin
        res.bytes = psb_pkg::BYTES_24;
        res.data  = pal_rdata & psb_pkg::MASK_24;
        xoff      = {1'b0, xpos, 1'b0} + {2'b00, xpos};
      end
      psb_pkg::DEPTH_16: begin
        res.bytes = psb_pkg::BYTES_16;
        res.data  = pal_rdata & psb_pkg::MASK_16;
        xoff      = {1'b0, xpos, 1'b0};
      end
      default: begin
        res.bytes = psb_pkg::BYTES_32;
        res.data  = pal_rdata;
        xoff      = {xpos, 2'b00};
      end
    endcase
    addr_sum = prod + PROD_W'(xoff);
    res.addr = addr_sum[psb_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= psb_pkg::SCALE_W'(1);
      left_margin <= '0;
      top_margin  <= '0;
      draw_width  <= '0;
      draw_height <= '0;
      col         <= '0;
      row         <= '0;
      col_sub     <= '0;
      row_sub     <= '0;
      src_x       <= '0;
      row_base    <= '0;
      fit_s       <= psb_pkg::SCALE_W'(1);
      span_w      <= SPW'(SRC_W);
      span_h      <= SPH'(SRC_H);
    end else begin
      case (state)
        psb_pkg::ST_IDLE: begin
          if (cmd_valid && is_draw) begin
            fit_s  <= psb_pkg::SCALE_W'(1);
            span_w <= SPW'(SRC_W);
            span_h <= SPH'(SRC_H);
          end
        end
        psb_pkg::ST_FIT: begin
          if (fit_more) begin
            fit_s  <= fit_s + psb_pkg::SCALE_W'(1);
            span_w <= span_w + SPW'(SRC_W);
            span_h <= span_h + SPH'(SRC_H);
          end else begin
            // margin is half the slack; draw size is the span clipped to the screen
            scale       <= fit_s;
            left_margin <= w_gt ? diff_w[DW-1:1] : '0;
            top_margin  <= h_gt ? diff_h[DW-1:1] : '0;
            draw_width  <= w_gt ? DW'(span_w) : w_sat;
            draw_height <= h_gt ? DW'(span_h) : h_sat;
          end
        end
        psb_pkg::ST_OUT: begin
          if (!res_full) begin
            if (last_col) begin
              col     <= '0;
              col_sub <= '0;
              src_x   <= '0;
              if (last_row) begin
                row      <= '0;
                row_sub  <= '0;
                row_base <= '0;
              end else begin
                row <= row + psb_pkg::CNT_W'(1);
                if (row_wrap) begin
                  row_sub  <= '0;
                  row_base <= row_base + FA_W'(SRC_W);
                end else begin
                  row_sub <= row_sub + psb_pkg::SCALE_W'(1);
                end
              end
            end else begin
              col <= col + psb_pkg::CNT_W'(1);
              if (col_wrap) begin
                col_sub <= '0;
                src_x   <= src_x + SX_W'(1);
              end else begin
                col_sub <= col_sub + psb_pkg::SCALE_W'(1);
              end
            end
          end
        end
        default: begin
          fit_s <= fit_s;
        end
      endcase
    end
  end

endmodule

/* hdl/palette_scaler_blit.sv */
// Top level of the palette scaler blitter: config registers, front, back, result queue.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  input     | push / full        | kind, palette_index, palette_color,
//            |                    | pixel_address, pixel_value
//  result    | pop / empty        | fb_address, fb_data, byte_count, frame_last
//  config    | cfg_write          | cfg_index, cfg_data
//
// Palette and pixel writes are stored as they are popped in the back end; a draw word
// steps through command pop, frame read, palette read and output, and the first draw of
// a frame first runs the scale search loop, which tries scales up to 31.
// The front queue holds four commands and the result queue two words, so input and
// output stall independently. Reset is synchronous; the palette and frame stores
// are not cleared and hold garbage until written.
module palette_scaler_blit #(
  parameter int SRC_W = psb_pkg::DEF_SRC_W,
  parameter int SRC_H = psb_pkg::DEF_SRC_H
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  kind,
  input  logic [7:0]                  palette_index,
  input  logic [psb_pkg::COLOR_W-1:0] palette_color,
  input  logic [psb_pkg::INDEX_W-1:0] pixel_address,
  input  logic [psb_pkg::PIX_W-1:0]   pixel_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [psb_pkg::ADDR_W-1:0]  fb_address,
  output logic [psb_pkg::COLOR_W-1:0] fb_data,
  output logic [psb_pkg::BYTES_W-1:0] byte_count,
  output logic                        frame_last,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [psb_pkg::CFG_W-1:0]   cfg_data
);

  psb_pkg::cfg_t    cfg;
  logic             cmd_valid;
  psb_pkg::cmd_t    cmd;
  logic             cmd_pop;
  logic             res_push;
  psb_pkg::result_t res;
  logic             res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= psb_pkg::DIM_W'(640);
      cfg.screen_height <= psb_pkg::DIM_W'(480);
      cfg.row_pitch     <= psb_pkg::PITCH_W'(2560);
      cfg.depth_mode    <= psb_pkg::DEPTH_32;
    end else if (cfg_write) begin
      case (cfg_index)
        psb_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[psb_pkg::DIM_W-1:0];
        psb_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[psb_pkg::DIM_W-1:0];
        psb_pkg::CFG_ROW_PITCH:     cfg.row_pitch     <= cfg_data[psb_pkg::PITCH_W-1:0];
        psb_pkg::CFG_DEPTH_MODE:    cfg.depth_mode    <= cfg_data[1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  psb_front #(
    .SRC_W (SRC_W),
    .SRC_H (SRC_H)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  psb_back #(
    .SRC_W (SRC_W),
    .SRC_H (SRC_H)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  psb_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .empty      (empty),
    .pop        (pop),
    .fb_address (fb_address),
    .fb_data    (fb_data),
    .byte_count (byte_count),
    .frame_last (frame_last)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for palette_scaler_blit: predicts and checks every
// framebuffer word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psb_pkg::*;

  localparam int SRC_W        = DEF_SRC_W;
  localparam int SRC_H        = DEF_SRC_H;
  localparam int FRAME_PIXELS = SRC_W * SRC_H;
  localparam int unsigned CNT_MASK = (1 << CNT_W) - 1;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [1:0] DEPTH_UNUSED = 2'd3;

  // quiet time before a register write: four queued commands, worst case scale search each
  localparam int SETTLE_CYCLES = 160;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 200;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         pal_index;
    logic [COLOR_W-1:0] pal_color;
    logic [INDEX_W-1:0] src_addr;
    logic [PIX_W-1:0]   src_value;
  } blit_cmd_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          kind = '0;
  logic [7:0]          palette_index = '0;
  logic [COLOR_W-1:0]  palette_color = '0;
  logic [INDEX_W-1:0]  pixel_address = '0;
  logic [PIX_W-1:0]    pixel_value = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [ADDR_W-1:0]   fb_address;
  logic [COLOR_W-1:0]  fb_data;
  logic [BYTES_W-1:0]  byte_count;
  logic                frame_last;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  palette_scaler_blit #(.SRC_W(SRC_W), .SRC_H(SRC_H)) u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .palette_index(palette_index), .palette_color(palette_color),
    .pixel_address(pixel_address), .pixel_value(pixel_value),
    .empty(empty), .pop(pop), .fb_address(fb_address), .fb_data(fb_data),
    .byte_count(byte_count), .frame_last(frame_last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------- predictor ----------------
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  bit                 pal_seen [PAL_DEPTH];
  logic [PIX_W-1:0]   src_mem [FRAME_PIXELS];
  bit                 src_seen [FRAME_PIXELS];
  int unsigned reg_width = 640, reg_height = 480, reg_pitch = 2560;
  logic [1:0]  reg_depth = DEPTH_32;
  int unsigned col_pos = 0, row_pos = 0, cur_scale = 1;
  int unsigned left_off = 0, top_off = 0, span_w = 0, span_h = 0;

  result_t fb_writes_due [$];

  int error_count = 0;
  int cmds_sent = 0;
  int words_checked = 0;
  int frames_done = 0;

  function automatic void fit_span(input int unsigned dim, input int unsigned src,
                                   input int unsigned s, output int unsigned off,
                                   output int unsigned size);
    int unsigned full_span;
    full_span = src * s;
    off  = dim > full_span ? (dim - full_span) / 2 : 0;
    size = full_span > dim ? dim : full_span;
  endfunction

  function automatic void latch_geometry();
    int unsigned w, h, s;
    w = reg_width > SCREEN_CAP ? SCREEN_CAP : reg_width;
    h = reg_height > SCREEN_CAP ? SCREEN_CAP : reg_height;
    s = (h / SRC_H < w / SRC_W) ? h / SRC_H : w / SRC_W;
    if (s == 0) s = 1;
    if (s > SCALE_CAP) s = SCALE_CAP;
    cur_scale = s;
    fit_span(w, SRC_W, s, left_off, span_w);
    fit_span(h, SRC_H, s, top_off, span_h);
  endfunction

  // Geometry only changes at the top of a frame, so latching early is harmless.
  function automatic void frame_start_latch();
    if (col_pos == 0 && row_pos == 0) latch_geometry();
  endfunction

  function automatic bit predict_fb_write(input blit_cmd_t c, output result_t w);
    int unsigned idx;
    logic [COLOR_W-1:0] color;
    logic [63:0] byte_addr;
    bit last_col, last_row;
    w = '0;
    case (c.kind)
      KIND_PALETTE: begin
        pal_mem[c.pal_index]  = c.pal_color;
        pal_seen[c.pal_index] = 1'b1;
        return 1'b0;
      end
      KIND_PIXEL: begin
        if (c.src_addr < FRAME_PIXELS) begin
          src_mem[c.src_addr]  = c.src_value;
          src_seen[c.src_addr] = 1'b1;
        end
        return 1'b0;
      end
      KIND_DRAW: begin
        frame_start_latch();
        if (span_w == 0 || span_h == 0) return 1'b0;
        idx = (row_pos / cur_scale) * SRC_W + col_pos / cur_scale;
        color = idx < FRAME_PIXELS ? pal_mem[src_mem[idx]] : '0;
        case (reg_depth)
          DEPTH_24: begin
            w.bytes = BYTES_24;
            w.data  = color & MASK_24;
          end
          DEPTH_16: begin
            w.bytes = BYTES_16;
            w.data  = color & MASK_16;
          end
          default: begin
            w.bytes = BYTES_32;
            w.data  = color;
          end
        endcase
        byte_addr = 64'(top_off + row_pos) * 64'(reg_pitch)
                  + 64'(left_off + col_pos) * 64'(w.bytes);
        w.addr = byte_addr[ADDR_W-1:0];
        last_col = col_pos + 1 >= span_w;
        last_row = row_pos + 1 >= span_h;
        w.last = last_col && last_row;
        if (last_col) begin
          col_pos = 0;
          row_pos = last_row ? 0 : ((row_pos + 1) & CNT_MASK);
        end else begin
          col_pos = (col_pos + 1) & CNT_MASK;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------- input side ----------------
  bit tx_bursty = 1'b1;
  int unsigned burst_left = 0;

  function automatic blit_cmd_t cmd_of(logic [1:0] k, logic [7:0] pidx,
                                       logic [COLOR_W-1:0] pcol,
                                       logic [INDEX_W-1:0] addr, logic [PIX_W-1:0] val);
    blit_cmd_t c;
    c.kind      = k;
    c.pal_index = pidx;
    c.pal_color = pcol;
    c.src_addr  = addr;
    c.src_value = val;
    return c;
  endfunction

  function automatic blit_cmd_t random_cmd(logic [1:0] k);
    return cmd_of(k, 8'($urandom), $urandom, 16'($urandom), 8'($urandom));
  endfunction

  // mostly the top-left corner that small frames read, some anywhere, some past the frame
  function automatic logic [INDEX_W-1:0] biased_src_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return INDEX_W'($urandom_range(0, 7) * SRC_W + $urandom_range(0, 31));
    if (r < 85) return INDEX_W'($urandom_range(0, FRAME_PIXELS - 1));
    return INDEX_W'($urandom_range(FRAME_PIXELS, (1 << INDEX_W) - 1));
  endfunction

  task automatic send_cmd(input blit_cmd_t c);
    int unsigned gap;
    result_t w;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
        repeat (gap) begin
          @(negedge clk);
          push <= 1'b0;
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    push          <= 1'b1;
    kind          <= c.kind;
    palette_index <= c.pal_index;
    palette_color <= c.pal_color;
    pixel_address <= c.src_addr;
    pixel_value   <= c.src_value;
    do @(posedge clk); while (full);
    cmds_sent++;
    if (predict_fb_write(c, w)) fb_writes_due.push_back(w);
  endtask

  // Make sure the next draw step only reads written frame and palette entries.
  task automatic send_draw();
    int unsigned idx;
    blit_cmd_t c;
    frame_start_latch();
    if (span_w != 0 && span_h != 0) begin
      idx = (row_pos / cur_scale) * SRC_W + col_pos / cur_scale;
      if (!src_seen[idx]) begin
        c = random_cmd(KIND_PIXEL);
        c.src_addr = INDEX_W'(idx);
        send_cmd(c);
      end
      if (!pal_seen[src_mem[idx]]) begin
        c = random_cmd(KIND_PALETTE);
        c.pal_index = src_mem[idx];
        send_cmd(c);
      end
    end
    send_cmd(random_cmd(KIND_DRAW));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_index_t idx, input int unsigned v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(v);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h,
                              input int unsigned pitch, input logic [1:0] depth);
    wait_drained();
    // writes and empty draws leave no word behind, so give them time to retire
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_put(CFG_SCREEN_WIDTH, w);
    cfg_put(CFG_SCREEN_HEIGHT, h);
    cfg_put(CFG_ROW_PITCH, pitch);
    cfg_put(CFG_DEPTH_MODE, depth);
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_width  = w % (1 << DIM_W);
    reg_height = h % (1 << DIM_W);
    reg_pitch  = pitch % (1 << PITCH_W);
    reg_depth  = depth;
  endtask

  // ---------------- output side ----------------
  int unsigned rx_mode = 1;
  int unsigned rx_tick = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= (rx_tick % 7) < 4;
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst && pop && !empty) begin
      if (fb_writes_due.size() == 0) begin
        report_error($sformatf("unexpected word addr %h data %h", fb_address, fb_data));
      end else begin
        want = fb_writes_due.pop_front();
        if (fb_address !== want.addr)
          report_error($sformatf("word %0d fb_address %h, want %h",
                                 words_checked, fb_address, want.addr));
        if (fb_data !== want.data)
          report_error($sformatf("word %0d fb_data %h, want %h",
                                 words_checked, fb_data, want.data));
        if (byte_count !== want.bytes)
          report_error($sformatf("word %0d byte_count %0d, want %0d",
                                 words_checked, byte_count, want.bytes));
        if (frame_last !== want.last)
          report_error($sformatf("word %0d frame_last %b, want %b",
                                 words_checked, frame_last, want.last));
        if (want.last) frames_done++;
        words_checked++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                 idle_cycles, fb_writes_due.size());
        $display("palette_scaler_blit regression: fail");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    write_config(2, 2, 1, DEPTH_32);
    send_cmd(cmd_of(KIND_PALETTE, 8'd0, 32'h0, '0, '0));
    send_cmd(cmd_of(KIND_PALETTE, 8'd255, 32'hffff_ffff, '0, '0));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'd0, 8'd255));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'(FRAME_PIXELS - 1), 8'd0));
    // past the end of the frame: dropped
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'(FRAME_PIXELS), 8'd0));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'hffff, 8'd0));
    send_cmd(cmd_of(KIND_UNUSED, 8'hff, 32'hffff_ffff, 16'hffff, 8'hff));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'd1, 8'd0));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'(SRC_W), 8'd255));
    send_cmd(cmd_of(KIND_PIXEL, '0, '0, 16'(SRC_W + 1), 8'd0));
    repeat (4) send_draw();
    write_config(1, 1, 1 << (PITCH_W - 1), DEPTH_24);
    send_draw();
    write_config(1, 1, 1 << (PITCH_W - 1), DEPTH_16);
    send_draw();
    write_config(1, 1, 1 << (PITCH_W - 1), DEPTH_UNUSED);
    send_draw();
    // zero-sized draw area: no word, counters stay put
    write_config(0, 1, 100, DEPTH_32);
    repeat (2) send_draw();
    write_config(1, 0, 100, DEPTH_32);
    send_draw();
    write_config(1, 1, 1, DEPTH_32);
    send_draw();
  endtask

  task automatic test_small_frames(input int phases);
    int unsigned w, h, pitch, draws_left, r;
    blit_cmd_t c;
    repeat (phases) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      h = $urandom_range(1, 6);
      r = $urandom_range(0, 3);
      pitch = (r == 0) ? 1 : (r == 1) ? (1 << (PITCH_W - 1)) : $urandom_range(1, 16384);
      write_config(w, h, pitch, 2'($urandom_range(0, 3)));
      rx_mode = $urandom_range(0, 3);
      tx_bursty = $urandom_range(0, 3) != 0;
      draws_left = (w == 0) ? 3 : w * h * $urandom_range(1, 2);
      while (draws_left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_draw();
          draws_left--;
        end else if (r < 85) begin
          c = random_cmd(KIND_PIXEL);
          c.src_addr = biased_src_addr();
          send_cmd(c);
        end else if (r < 95) begin
          send_cmd(random_cmd(KIND_PALETTE));
        end else begin
          send_cmd(random_cmd(KIND_UNUSED));
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering: both queues fill and full rises.
  task automatic test_backpressure();
    write_config(8, 5, 640, DEPTH_32);
    rx_mode = 0;
    tx_bursty = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (40) send_draw();
    wait_drained();
    tx_bursty = 1'b1;
  endtask

  // one column, height at the cap: large top margin
  task automatic test_tall_frame();
    write_config(1, 4096, 1 << (PITCH_W - 1), 2'($urandom_range(0, 3)));
    rx_mode = 2;
    repeat (SRC_H) send_draw();
  endtask

  // Scale 2 with both margins; pitch and depth are live, so they change between chunks.
  task automatic test_scaled_partial();
    int unsigned pitch;
    repeat (4) begin
      pitch = ($urandom_range(0, 1) == 0) ? (1 << (PITCH_W - 1)) : $urandom_range(1, 16384);
      write_config((1 << DIM_W) - 1, 599, pitch, 2'($urandom_range(0, 3)));
      rx_mode = $urandom_range(0, 3);
      repeat (110) send_draw();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_small_frames(6);
    test_backpressure();
    test_tall_frame();
    test_scaled_partial();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fb_writes_due.size() != 0)
      report_error($sformatf("%0d words never arrived", fb_writes_due.size()));
    $display("%0d command words sent, %0d framebuffer words checked, %0d frames closed",
             cmds_sent, words_checked, frames_done);
    $display("covered all depth modes, scale 1 and 2, margins, empty draw area, back-pressure");
    if (error_count == 0) begin
      $display("palette_scaler_blit regression: pass");
    end else begin
      $display("palette_scaler_blit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/psb_pkg.sv
hdl/psb_ram.sv
hdl/psb_front.sv
hdl/psb_outq.sv
hdl/psb_back.sv
hdl/palette_scaler_blit.sv
test/tb_top.sv
